// ----- hw/rtl/dpfd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the delimiter pair frame detector.
// No dependencies; imported by every module of the block.
package dpfd_pkg;

  localparam int unsigned NUM_PAIR_REGS = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned IDX_OUT_W     = 10;
  localparam int unsigned LEN_OUT_W     = 11;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_ZERO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_ONE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_TWO      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_THREE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIRS_ENABLED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT  = 3'd5;

  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } dpfd_op_e;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_TIMEOUT  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } dpfd_status_e;

  typedef struct packed {
    logic [NUM_PAIR_REGS-1:0][15:0] pair;
    logic [2:0]                     pairs_enabled;
    logic [15:0]                    idle_timeout;
  } dpfd_cfg_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] pair_idx;
    logic [7:0] end_byte;
  } dpfd_match_t;

  typedef struct packed {
    dpfd_status_e         status;
    logic [IDX_OUT_W-1:0] start_index;
    logic [IDX_OUT_W-1:0] end_index;
    logic [LEN_OUT_W-1:0] frame_length;
    logic [1:0]           pair_index;
  } dpfd_result_t;

endpackage

// ----- hw/rtl/delimiter_pair_frame_detector.sv -----
`timescale 1ns / 1ps
// Top level of the delimiter pair frame detector: input and result registers.
// Depends on dpfd_pkg, dpfd_cfg_regs and dpfd_core.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o   | opcode_i, data_byte_i
//  out     | out_valid_o / out_stall_i | status_o, start/end_index_o,
//          |                           | frame_length_o, pair_index_o
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while no result is stalled. An item waits in the input
// register, where the delimiter compare and state update happen; a result shows
// on out_valid_o the cycle after it leaves that register. Reset clears the frame
// state and the configuration registers to zero.
// A stalled result holds only items that produce a result; others pass on.
module delimiter_pair_frame_detector import dpfd_pkg::*; #(
  parameter int unsigned BUFFER_SIZE = 1024,
  parameter int unsigned MAX_PAIRS   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [IDX_OUT_W-1:0] start_index_o,
  output logic [IDX_OUT_W-1:0] end_index_o,
  output logic [LEN_OUT_W-1:0] frame_length_o,
  output logic [1:0]           pair_index_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  dpfd_cfg_t    cfg;
  logic         item_valid_q;
  dpfd_op_e     op_q;
  logic [7:0]   byte_q;
  logic         has_result;
  dpfd_result_t result;
  dpfd_result_t out_q;
  logic         out_valid_q;
  logic         out_free;
  logic         item_go;
  logic         in_accept;

  assign cfg_ready_o = 1'b1;

  dpfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dpfd_core #(
    .BUFFER_SIZE (BUFFER_SIZE),
    .MAX_PAIRS   (MAX_PAIRS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_q),
    .item_go_i    (item_go),
    .op_i         (op_q),
    .byte_i       (byte_q),
    .cfg_i        (cfg),
    .has_result_o (has_result),
    .result_o     (result)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign item_go    = item_valid_q && (!has_result || out_free);
  assign in_stall_o = item_valid_q && !item_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_accept) begin
      item_valid_q <= 1'b1;
    end else if (item_go) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= dpfd_op_e'(opcode_i);
      byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_go && has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_go && has_result) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign start_index_o  = out_q.start_index;
  assign end_index_o    = out_q.end_index;
  assign frame_length_o = out_q.frame_length;
  assign pair_index_o   = out_q.pair_index;

endmodule

// ----- hw/rtl/dpfd_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file: delimiter pairs, enable count, idle timeout.
// Depends on dpfd_pkg.
module dpfd_cfg_regs import dpfd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output dpfd_cfg_t            cfg_o
);

  dpfd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PAIR_ZERO:     cfg_q.pair[0]       <= cfg_data_i;
        REG_PAIR_ONE:      cfg_q.pair[1]       <= cfg_data_i;
        REG_PAIR_TWO:      cfg_q.pair[2]       <= cfg_data_i;
        REG_PAIR_THREE:    cfg_q.pair[3]       <= cfg_data_i;
        REG_PAIRS_ENABLED: cfg_q.pairs_enabled <= cfg_data_i[2:0];
        REG_IDLE_TIMEOUT:  cfg_q.idle_timeout  <= cfg_data_i;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/dpfd_match.sv -----
`timescale 1ns / 1ps
// Parallel start-delimiter compare with priority to the lowest pair.
// Depends on dpfd_pkg.
module dpfd_match import dpfd_pkg::*; #(
  parameter int unsigned MAX_PAIRS = 4
) (
  input  dpfd_cfg_t   cfg_i,
  input  logic [7:0]  byte_i,
  output dpfd_match_t match_o
);

  logic [2:0] n_eff;

  assign n_eff = (cfg_i.pairs_enabled > 3'(MAX_PAIRS)) ? 3'(MAX_PAIRS)
                                                      : cfg_i.pairs_enabled;

  // Walk from the top down so the lowest matching pair wins
  always_comb begin
    match_o = '0;
    for (int i = MAX_PAIRS - 1; i >= 0; i--) begin
      if ((3'(i) < n_eff) && (cfg_i.pair[i][15:8] == byte_i)) begin
        match_o.hit      = 1'b1;
        match_o.pair_idx = 2'(i);
        match_o.end_byte = cfg_i.pair[i][7:0];
      end
    end
  end

endmodule

// ----- hw/rtl/dpfd_core.sv -----
`timescale 1ns / 1ps
// Frame state: ring position, open frame, length and idle counters.
// Depends on dpfd_pkg and dpfd_match.
module dpfd_core import dpfd_pkg::*; #(
  parameter int unsigned BUFFER_SIZE = 1024,
  parameter int unsigned MAX_PAIRS   = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  input  logic         item_go_i,
  input  dpfd_op_e     op_i,
  input  logic [7:0]   byte_i,
  input  dpfd_cfg_t    cfg_i,
  output logic         has_result_o,
  output dpfd_result_t result_o
);

  localparam int unsigned PW = $clog2(BUFFER_SIZE);
  localparam int unsigned LW = $clog2(BUFFER_SIZE + 1);

  logic          open_q,  open_d;
  logic [7:0]    end_q,   end_d;
  logic [1:0]    pair_q,  pair_d;
  logic [PW-1:0] start_q, start_d;
  logic [PW-1:0] wpos_q,  wpos_d;
  logic [LW-1:0] len_q,   len_d;
  logic [15:0]   idle_q,  idle_d;

  dpfd_match_t   match;
  logic [15:0]   idle_inc;
  logic [LW-1:0] len_inc;
  logic          emit;
  dpfd_status_e  emit_status;
  logic          emit_end;
  logic [LW-1:0] emit_len;

  logic [PW+IDX_OUT_W-1:0] start_wide, end_wide;
  logic [LW+LEN_OUT_W-1:0] len_wide;

  dpfd_match #(.MAX_PAIRS(MAX_PAIRS)) u_match (
    .cfg_i   (cfg_i),
    .byte_i  (byte_i),
    .match_o (match)
  );

  assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
  assign len_inc  = len_q + LW'(1);

  always_comb begin
    open_d      = open_q;
    end_d       = end_q;
    pair_d      = pair_q;
    start_d     = start_q;
    wpos_d      = wpos_q;
    len_d       = len_q;
    idle_d      = idle_q;
    emit        = 1'b0;
    emit_status = STATUS_DONE;
    emit_end    = 1'b0;
    emit_len    = len_q;
    if (op_i == OP_TICK) begin
      idle_d = idle_inc;
      if (open_q && (cfg_i.idle_timeout != 16'd0) && (idle_inc > cfg_i.idle_timeout)) begin
        emit        = 1'b1;
        emit_status = STATUS_TIMEOUT;
        open_d      = 1'b0;
        end_d       = '0;
        len_d       = '0;
      end
    end else begin
      wpos_d = (wpos_q == PW'(BUFFER_SIZE - 1)) ? '0 : wpos_q + PW'(1);
      idle_d = '0;
      if (!open_q) begin
        if (match.hit) begin
          open_d  = 1'b1;
          start_d = wpos_q;
          end_d   = match.end_byte;
          pair_d  = match.pair_idx;
          len_d   = LW'(1);
        end
      end else if (len_q == LW'(BUFFER_SIZE)) begin
        // frame would outgrow the ring; this byte is swallowed
        emit        = 1'b1;
        emit_status = STATUS_OVERFLOW;
        open_d      = 1'b0;
        end_d       = '0;
        len_d       = '0;
      end else begin
        len_d = len_inc;
        if (byte_i == end_q) begin
          emit     = 1'b1;
          emit_end = 1'b1;
          emit_len = len_inc;
          open_d   = 1'b0;
          end_d    = '0;
          len_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      end_q   <= '0;
      pair_q  <= '0;
      start_q <= '0;
      wpos_q  <= '0;
      len_q   <= '0;
      idle_q  <= '0;
    end else if (item_go_i) begin
      open_q  <= open_d;
      end_q   <= end_d;
      pair_q  <= pair_d;
      start_q <= start_d;
      wpos_q  <= wpos_d;
      len_q   <= len_d;
      idle_q  <= idle_d;
    end
  end

  // Fit internal widths to the fixed port widths
  assign start_wide = {{IDX_OUT_W{1'b0}}, start_q};
  assign end_wide   = {{IDX_OUT_W{1'b0}}, (emit_end ? wpos_q : {PW{1'b0}})};
  assign len_wide   = {{LEN_OUT_W{1'b0}}, emit_len};

  assign has_result_o          = item_valid_i && emit;
  assign result_o.status       = emit_status;
  assign result_o.start_index  = start_wide[IDX_OUT_W-1:0];
  assign result_o.end_index    = end_wide[IDX_OUT_W-1:0];
  assign result_o.frame_length = len_wide[LEN_OUT_W-1:0];
  assign result_o.pair_index   = pair_q;

endmodule

// ----- test/dpfd_frame_checker.sv -----
`timescale 1ns / 1ps
// Frame checker for the delimiter pair frame detector: tracks register writes,
// predicts every frame report from the accepted input and compares it.
// Depends on dpfd_pkg; instantiated next to the block by the testbench top.
module dpfd_frame_checker import dpfd_pkg::*; #(
  parameter int unsigned RING_DEPTH = 1024,
  parameter int unsigned MAX_PAIRS  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 opcode_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [1:0]           status_i,
  input  logic [IDX_OUT_W-1:0] start_index_i,
  input  logic [IDX_OUT_W-1:0] end_index_i,
  input  logic [LEN_OUT_W-1:0] frame_length_i,
  input  logic [1:0]           pair_index_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output int unsigned          mismatch_cnt_o,
  output int unsigned          frames_due_o
);

  // Shadow registers
  logic [15:0] pair_q [NUM_PAIR_REGS];
  logic [2:0]  pairs_on_q;
  logic [15:0] idle_limit_q;

  // Predicted framer state
  logic                 in_frame;
  logic [7:0]           close_byte;
  logic [1:0]           open_pair;
  logic [IDX_OUT_W-1:0] frame_head;
  logic [IDX_OUT_W-1:0] wr_pos;
  logic [LEN_OUT_W-1:0] held_len;
  logic [15:0]          idle_cnt;

  dpfd_result_t frames_due [$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  due_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign frames_due_o   = due_cnt;

  task automatic flag_mismatch(input string what);
    $display("[%0t] frame check: %s", $time, what);
    mismatch_cnt++;
  endtask

  function automatic void close_frame(input dpfd_status_e st, input logic [IDX_OUT_W-1:0] tail,
                                      input logic [LEN_OUT_W-1:0] len);
    dpfd_result_t r;
    r.status       = st;
    r.start_index  = frame_head;
    r.end_index    = tail;
    r.frame_length = len;
    r.pair_index   = open_pair;
    frames_due.push_back(r);
    in_frame   = 1'b0;
    close_byte = '0;
    held_len   = '0;
  endfunction

  function automatic void frame_step(input dpfd_op_e op, input logic [7:0] b);
    logic [IDX_OUT_W-1:0] pos;
    int unsigned          live;
    if (op == OP_TICK) begin
      if (idle_cnt != IDLE_MAX) idle_cnt = idle_cnt + 1'b1;
      if (in_frame && idle_limit_q != '0 && idle_cnt > idle_limit_q)
        close_frame(STATUS_TIMEOUT, '0, held_len);
      return;
    end
    pos      = wr_pos;
    wr_pos   = (int'(wr_pos) + 1 >= RING_DEPTH) ? '0 : wr_pos + 1'b1;
    idle_cnt = '0;
    if (!in_frame) begin
      live = (pairs_on_q > MAX_PAIRS) ? MAX_PAIRS : pairs_on_q;
      // first enabled pair with a matching start byte wins
      for (int unsigned i = 0; i < live && i < NUM_PAIR_REGS; i++) begin
        if (pair_q[i][15:8] == b) begin
          in_frame   = 1'b1;
          frame_head = pos;
          close_byte = pair_q[i][7:0];
          open_pair  = 2'(i);
          held_len   = LEN_OUT_W'(1);
          break;
        end
      end
      return;
    end
    // byte that would outgrow the ring is eaten by the drop
    if (int'(held_len) + 1 > RING_DEPTH) begin
      close_frame(STATUS_OVERFLOW, '0, held_len);
      return;
    end
    held_len = held_len + 1'b1;
    if (b == close_byte) close_frame(STATUS_DONE, pos, held_len);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dpfd_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PAIR_REGS; i++) pair_q[i] = '0;
      pairs_on_q   = '0;
      idle_limit_q = '0;
      in_frame     = 1'b0;
      close_byte   = '0;
      open_pair    = '0;
      frame_head   = '0;
      wr_pos       = '0;
      held_len     = '0;
      idle_cnt     = '0;
      frames_due.delete();
      due_cnt <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PAIR_ZERO, REG_PAIR_ONE, REG_PAIR_TWO, REG_PAIR_THREE: begin
            pair_q[cfg_index_i[1:0]] = cfg_data_i;
          end
          REG_PAIRS_ENABLED: pairs_on_q   = cfg_data_i[2:0];
          REG_IDLE_TIMEOUT:  idle_limit_q = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected report st %0d start %0d end %0d len %0d pair %0d",
                                  status_i, start_index_i, end_index_i, frame_length_i,
                                  pair_index_i));
        end else begin
          want = frames_due.pop_front();
          if (status_i !== want.status || start_index_i !== want.start_index ||
              end_index_i !== want.end_index || frame_length_i !== want.frame_length ||
              pair_index_i !== want.pair_index) begin
            flag_mismatch({$sformatf("got st %0d start %0d end %0d len %0d pair %0d, ",
                                     status_i, start_index_i, end_index_i, frame_length_i,
                                     pair_index_i),
                           $sformatf("want st %0d start %0d end %0d len %0d pair %0d",
                                     want.status, want.start_index, want.end_index,
                                     want.frame_length, want.pair_index)});
          end
        end
      end

      if (in_valid_i && !in_stall_i) frame_step(dpfd_op_e'(opcode_i), data_byte_i);

      due_cnt <= frames_due.size();
    end
  end

endmodule

// ----- test/tb_delimiter_pair_frame_detector.sv -----
`timescale 1ns / 1ps
// Testbench top for the delimiter pair frame detector: clock, reset, register
// setup, byte/tick stimulus and receiver back-pressure; the verdict comes from
// dpfd_frame_checker. Depends on dpfd_pkg and the block itself.
module tb_delimiter_pair_frame_detector;
  import dpfd_pkg::*;

  localparam int unsigned RING_DEPTH    = 1024;
  localparam int unsigned MAX_PAIRS     = 4;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_ITEMS   = 80;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned LIMIT_NS      = 10_000_000;

  // indexes past the register map, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 opcode_i    = 1'b0;
  logic [7:0]           data_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           status_o;
  logic [IDX_OUT_W-1:0] start_index_o;
  logic [IDX_OUT_W-1:0] end_index_o;
  logic [LEN_OUT_W-1:0] frame_length_o;
  logic [1:0]           pair_index_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0]          cfg_data_i  = '0;

  int unsigned mismatch_cnt;
  int unsigned frames_due;

  // stimulus-side copy of the setup, only used to shape traffic
  logic [15:0] cur_pair [NUM_PAIR_REGS];
  logic [2:0]  cur_en;
  logic [15:0] cur_to;

  logic        calm         = 1'b0;
  logic        rx_hold_req  = 1'b0;
  bit          rx_hold_done = 1'b0;
  int unsigned sent_cnt     = 0;

  delimiter_pair_frame_detector #(
    .BUFFER_SIZE (RING_DEPTH),
    .MAX_PAIRS   (MAX_PAIRS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .start_index_o  (start_index_o),
    .end_index_o    (end_index_o),
    .frame_length_o (frame_length_o),
    .pair_index_o   (pair_index_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  dpfd_frame_checker #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_PAIRS  (MAX_PAIRS)
  ) frame_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .opcode_i       (opcode_i),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .start_index_i  (start_index_o),
    .end_index_i    (end_index_o),
    .frame_length_i (frame_length_o),
    .pair_index_i   (pair_index_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .frames_due_o   (frames_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("delimiter_pair_frame_detector: mismatch");
    $finish;
  end

  // Receiver: random stalls, one long hold-off when asked, none while calm.
  initial begin : rx_side
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !rx_hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_done = 1'b1;
      end
      out_stall_i <= !calm && ($urandom_range(99) < 33);
    end
  end

  // valid is left high after a transaction; the next call replaces the item or wait_drained lowers it
  task automatic send_item(input dpfd_op_e op, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] pick_byte();
    logic [15:0] pr;
    pr = cur_pair[$urandom_range(NUM_PAIR_REGS - 1)];
    if ($urandom_range(99) < 40) return $urandom_range(1) ? pr[15:8] : pr[7:0];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_body(input int unsigned count, input logic [7:0] avoid,
                           input bit with_ticks);
    logic [7:0] b;
    repeat (count) begin
      if (with_ticks && $urandom_range(99) < 15) begin
        send_tick();
      end else begin
        b = pick_byte();
        if (b == avoid) b = ~avoid;
        send_item(OP_BYTE, b);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_due != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Only while idle: all reports in, plus a SETTLE_CYCLES wait for a silent item in flight.
  task automatic set_config(input logic [15:0] p0, input logic [15:0] p1,
                            input logic [15:0] p2, input logic [15:0] p3,
                            input logic [2:0] en, input logic [15:0] to);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_PAIR_ZERO, p0);
    write_reg(REG_PAIR_ONE, p1);
    write_reg(REG_PAIR_TWO, p2);
    write_reg(REG_PAIR_THREE, p3);
    write_reg(REG_PAIRS_ENABLED, {13'($urandom), en});
    write_reg(REG_IDLE_TIMEOUT, to);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    cfg_valid_i <= 1'b0;
    cur_pair[0] = p0;
    cur_pair[1] = p1;
    cur_pair[2] = p2;
    cur_pair[3] = p3;
    cur_en      = en;
    cur_to      = to;
  endtask

  initial begin : stimulus
    logic [15:0] p [NUM_PAIR_REGS];
    logic [7:0]  pb;
    logic [2:0]  en;
    logic [15:0] to;
    int unsigned sel;
    int unsigned k;
    int unsigned live;
    int unsigned tick_n;
    int unsigned phase_start;
    bit          paused;
    bit          hold_asked;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: start equal to end, extremes of the byte, timeout, noise.
    set_config(16'h7E7E, 16'h0203, 16'hFF00, 16'h00FF, 3'd4, 16'd2);
    send_item(OP_BYTE, 8'h7E);
    send_item(OP_BYTE, 8'h7E);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, 8'h7E);
    send_item(OP_BYTE, 8'h03);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_tick();
    send_item(OP_BYTE, 8'h02);
    send_tick();
    send_tick();
    send_tick();
    send_item(OP_BYTE, 8'h55);
    send_tick();
    // no pairs in use: nothing opens
    set_config(16'h7E7E, 16'h0203, 16'hFF00, 16'h00FF, 3'd0, 16'd0);
    send_item(OP_BYTE, 8'h7E);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_tick();

    // Ring-sized frame that overflows on a start byte.
    set_config(16'hA55A, 16'($urandom), 16'($urandom), 16'($urandom), 3'd1, 16'd1);
    send_tick();
    send_tick();
    set_config(16'hA55A, 16'($urandom), 16'($urandom), 16'($urandom), 3'd1, 16'd0);
    send_item(OP_BYTE, 8'hA5);
    send_body(RING_DEPTH - 1, 8'h5A, 1'b0);
    send_item(OP_BYTE, 8'hA5);
    send_item(OP_BYTE, 8'h5A);
    send_item(OP_BYTE, 8'hA5);
    send_item(OP_BYTE, 8'h5A);

    // Random phases, mostly well-formed frames over a delimiter-heavy alphabet.
    hold_asked = 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int s = 0; s < NUM_PAIR_REGS; s++) begin
        pb   = 8'($urandom_range(255));
        p[s] = {pb, ($urandom_range(99) < 30) ? pb : 8'($urandom_range(255))};
      end
      case (ph)
        0: begin en = 3'd4; to = 16'd0; end
        1: begin en = 3'd1; to = 16'd1; end
        2: begin en = 3'd7; to = 16'hFFFF; end
        3: begin en = 3'd2; to = 16'd4; end
        4: begin en = 3'd4; to = 16'd0; end
        5: begin en = 3'd3; to = 16'd2; end
        6: begin
          en   = 3'd5;
          to   = 16'd6;
          p[0] = 16'h0000;
          p[1] = 16'hFFFF;
          p[2] = 16'h00AA;  // shadowed by pair zero
        end
        default: begin en = 3'd4; to = 16'($urandom_range(20, 1)); end
      endcase
      set_config(p[0], p[1], p[2], p[3], en, to);
      calm <= (ph == 5);
      live        = (cur_en > MAX_PAIRS) ? MAX_PAIRS : cur_en;
      phase_start = sent_cnt;
      paused      = 1'b0;
      while (sent_cnt - phase_start < PHASE_ITEMS) begin
        if (ph == 2 && !paused && sent_cnt - phase_start > 40) begin
          wait_drained();
          paused = 1'b1;
        end
        if (ph == 4 && !hold_asked && sent_cnt - phase_start > 40) begin
          rx_hold_req <= 1'b1;
          hold_asked = 1'b1;
        end
        sel = $urandom_range(99);
        k   = $urandom_range(live - 1);
        if (sel < 60) begin
          send_item(OP_BYTE, cur_pair[k][15:8]);
          send_body($urandom_range(10), cur_pair[k][7:0], 1'b1);
          send_item(OP_BYTE, cur_pair[k][7:0]);
        end else if (sel < 75) begin
          // open a frame and send ticks, enough to time it out when the timeout is 1 to 16
          send_item(OP_BYTE, cur_pair[k][15:8]);
          send_body($urandom_range(4), cur_pair[k][7:0], 1'b0);
          tick_n = (cur_to != 0 && cur_to <= 16) ? cur_to + 1 : $urandom_range(3, 1);
          repeat (tick_n) send_tick();
        end else if (sel < 90) begin
          repeat ($urandom_range(6, 1)) begin
            if ($urandom_range(3) == 0) send_tick();
            else send_item(OP_BYTE, 8'($urandom_range(255)));
          end
        end else begin
          // truncated frame, left open for whatever follows
          send_item(OP_BYTE, cur_pair[k][15:8]);
          send_body($urandom_range(5), cur_pair[k][7:0], 1'b1);
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && frames_due == 0) begin
      $display("delimiter_pair_frame_detector: match");
    end else begin
      $display("delimiter_pair_frame_detector: mismatch");
    end
    $finish;
  end

endmodule
